/* rtl/double_ended_queue_defines.svh */
// assertion macros for the double-ended queue checker
// no dependencies
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DEQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque assertion failed");

// next-cycle implication, disabled during reset
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque assertion failed");

`endif

/* rtl/deq_pkg.sv */
// shared constants and codes for the double-ended queue
// no dependencies
package deq_pkg;

   localparam int DEQ_DEPTH = 1024;
   localparam int DATA_W    = 32;
   localparam int KIND_W    = 3;
   localparam int STATUS_W  = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_QUERY      = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

endpackage

/* rtl/deq_ram.sv */
// entry store of the double-ended queue: one write port, one registered read port
// depends on deq_pkg
module deq_ram #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [deq_pkg::DATA_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [deq_pkg::DATA_W-1:0]  rd_data
);

   logic [deq_pkg::DATA_W-1:0] mem [DEPTH];
   logic [deq_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/double_ended_queue.sv */
// top level of the double-ended queue: pointers, occupancy, cached end words
// depends on deq_pkg and deq_ram
//
//   channel   ports                              transaction
//   request   start, busy, req_kind, req_value   start high while busy low
//   response  rsp_valid, rsp_*                   rsp_valid high for one cycle
//
// every transaction runs through the store access, then the read state, in
// which the cached front or back word is refreshed from the read data
// a new request can be accepted in the cycle the response is shown
// synchronous reset empties the queue; store contents are not cleared
// the receiver cannot stall the response
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [deq_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [deq_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   output logic signed [deq_pkg::DATA_W-1:0]   rsp_popped_value,
   output logic [deq_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [deq_pkg::DATA_W-1:0]   rsp_front_value,
   output logic signed [deq_pkg::DATA_W-1:0]   rsp_back_value,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_entry_count,
   output logic                                rsp_is_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DW    = deq_pkg::DATA_W;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type                      state_ff, state_in;
   logic                           busy_ff, busy_in;
   logic [PTR_W-1:0]               fp_ff, fp_in;
   logic [PTR_W-1:0]               bp_ff, bp_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [DW-1:0]                  front_ff, front_in;
   logic [DW-1:0]                  back_ff, back_in;
   logic [DW-1:0]                  popped_ff, popped_in;
   logic [deq_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic                           rd_front_ff, rd_front_in;
   logic                           rd_back_ff, rd_back_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                  rsp_popped_ff, rsp_popped_in;
   logic [deq_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [DW-1:0]                  rsp_front_ff, rsp_front_in;
   logic [DW-1:0]                  rsp_back_ff, rsp_back_in;
   logic [CNT_W-1:0]               rsp_count_ff, rsp_count_in;
   logic                           rsp_empty_ff, rsp_empty_in;

   logic                           accept;
   logic                           is_full;
   logic                           is_empty;
   logic [PTR_W-1:0]               fp_prev, fp_next, bp_prev, bp_next;
   logic                           wr_en;
   logic [PTR_W-1:0]               wr_addr;
   logic [DW-1:0]                  wr_data;
   logic [PTR_W-1:0]               rd_addr;
   logic [DW-1:0]                  rd_data;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
   endfunction

   assign accept   = start && !busy_ff;
   assign is_full  = (cnt_ff == CNT_W'(DEPTH));
   assign is_empty = (cnt_ff == '0);
   assign fp_prev  = ptr_prev(fp_ff);
   assign fp_next  = ptr_next(fp_ff);
   assign bp_prev  = ptr_prev(bp_ff);
   assign bp_next  = ptr_next(bp_ff);

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      fp_in         = fp_ff;
      bp_in         = bp_ff;
      cnt_in        = cnt_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      rd_front_in   = rd_front_ff;
      rd_back_in    = rd_back_ff;
      rsp_valid_in  = 1'b0;
      rsp_popped_in = rsp_popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = bp_ff;
      wr_data       = req_value;
      rd_addr       = fp_next;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_READ;
               busy_in     = 1'b1;
               popped_in   = '0;
               status_in   = deq_pkg::STATUS_OK;
               rd_front_in = 1'b0;
               rd_back_in  = 1'b0;
               case (req_kind)
                  deq_pkg::KIND_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = deq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        fp_in    = fp_prev;
                        wr_en    = 1'b1;
                        wr_addr  = fp_prev;
                        front_in = req_value;
                        if (is_empty) begin
                           back_in = req_value;
                        end
                        cnt_in   = cnt_ff + 1'b1;
                     end
                  end
                  deq_pkg::KIND_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = deq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        bp_in   = bp_next;
                        wr_en   = 1'b1;
                        wr_addr = bp_ff;
                        back_in = req_value;
                        if (is_empty) begin
                           front_in = req_value;
                        end
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  deq_pkg::KIND_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = deq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        popped_in   = front_ff;
                        fp_in       = fp_next;
                        rd_addr     = fp_next;
                        rd_front_in = 1'b1;
                        cnt_in      = cnt_ff - 1'b1;
                     end
                  end
                  deq_pkg::KIND_POP_BACK: begin
                     if (is_empty) begin
                        status_in = deq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        popped_in  = back_ff;
                        bp_in      = bp_prev;
                        rd_addr    = ptr_prev(bp_prev);
                        rd_back_in = 1'b1;
                        cnt_in     = cnt_ff - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
            if (rd_front_ff) begin
               front_in = rd_data;
            end
            if (rd_back_ff) begin
               back_in = rd_data;
            end
            rsp_valid_in  = 1'b1;
            rsp_popped_in = popped_ff;
            rsp_status_in = status_ff;
            rsp_front_in  = is_empty ? '0 : front_in;
            rsp_back_in   = is_empty ? '0 : back_in;
            rsp_count_in  = cnt_ff;
            rsp_empty_in  = is_empty;
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         fp_ff        <= '0;
         bp_ff        <= '0;
         cnt_ff       <= '0;
         rd_front_ff  <= 1'b0;
         rd_back_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         fp_ff        <= fp_in;
         bp_ff        <= bp_in;
         cnt_ff       <= cnt_in;
         rd_front_ff  <= rd_front_in;
         rd_back_ff   <= rd_back_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      front_ff      <= front_in;
      back_ff       <= back_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   deq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_back_value   = rsp_back_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;

endmodule

/* rtl/deq_chk.sv */
// port-level checker for the double-ended queue, bound to the top level
// depends on deq_pkg, double_ended_queue_defines.svh and double_ended_queue
`include "double_ended_queue_defines.svh"

module deq_chk #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic signed [deq_pkg::DATA_W-1:0]   rsp_front_value,
   input logic signed [deq_pkg::DATA_W-1:0]   rsp_back_value,
   input logic [$clog2(DEPTH+1)-1:0]          rsp_entry_count,
   input logic                                rsp_is_empty
);

   `DEQ_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `DEQ_ASSERT_NEXT(a_accept_rsp, clock, reset, start && !busy, !rsp_valid ##1 rsp_valid)
   `DEQ_ASSERT_IMPLY(a_rsp_not_busy, clock, reset, rsp_valid, !busy)
   `DEQ_ASSERT_IMPLY(a_empty_flag, clock, reset, rsp_valid, rsp_is_empty == (rsp_entry_count == '0))
   `DEQ_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && rsp_is_empty, rsp_front_value == '0 && rsp_back_value == '0)

endmodule

bind double_ended_queue deq_chk #(
   .DEPTH (DEPTH)
) u_deq_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_front_value (rsp_front_value),
   .rsp_back_value  (rsp_back_value),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty)
);

/* verif/tb_top.sv */
// self-checking testbench for double_ended_queue: directed, full-queue and random traffic
// predicts every response with a queue-based mirror of the deque
// depends on deq_pkg and the double_ended_queue rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD  = 4;
   localparam int DEPTH        = deq_pkg::DEQ_DEPTH;
   localparam int DATA_W       = deq_pkg::DATA_W;
   localparam int KIND_W       = deq_pkg::KIND_W;
   localparam int STATUS_W     = deq_pkg::STATUS_W;
   localparam int COUNT_W      = $clog2(DEPTH + 1);
   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic signed [DATA_W-1:0] popped;
      deq_pkg::status_type      status;
      logic signed [DATA_W-1:0] front;
      logic signed [DATA_W-1:0] back;
      logic [COUNT_W-1:0]       count;
      logic                     empty;
   } deq_outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [KIND_W-1:0]         req_kind = deq_pkg::KIND_QUERY;
   logic signed [DATA_W-1:0]  req_value = '0;
   logic                      rsp_valid;
   logic signed [DATA_W-1:0]  rsp_popped_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic signed [DATA_W-1:0]  rsp_front_value;
   logic signed [DATA_W-1:0]  rsp_back_value;
   logic [COUNT_W-1:0]        rsp_entry_count;
   logic                      rsp_is_empty;

   logic signed [DATA_W-1:0]  held_words[$];
   deq_outcome_type           pending_outcomes[$];
   int unsigned               gap_odds = 0;
   int unsigned               cycle_count = 0;
   int unsigned               mismatch_count = 0;
   int unsigned               sent_count = 0;
   int unsigned               checked_count = 0;
   int unsigned               full_drops = 0;
   int unsigned               empty_pops = 0;
   int unsigned               peak_count = 0;

   double_ended_queue #(
      .DEPTH(DEPTH)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_popped_value(rsp_popped_value),
      .rsp_status      (rsp_status),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d responses outstanding", $time,
                  pending_outcomes.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic deq_outcome_type apply_deque_op(input logic [KIND_W-1:0] kind,
                                                      input logic signed [DATA_W-1:0] value);
      deq_outcome_type o;
      o.popped = '0;
      o.status = deq_pkg::STATUS_OK;
      case (kind)
         deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
            if (held_words.size() >= DEPTH) o.status = deq_pkg::STATUS_PUSH_FULL;
            else if (kind == deq_pkg::KIND_PUSH_FRONT) held_words.push_front(value);
            else held_words.push_back(value);
         end
         deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
            if (held_words.size() == 0) o.status = deq_pkg::STATUS_POP_EMPTY;
            else if (kind == deq_pkg::KIND_POP_FRONT) o.popped = held_words.pop_front();
            else o.popped = held_words.pop_back();
         end
         default: ;
      endcase
      o.count = COUNT_W'(held_words.size());
      o.empty = (held_words.size() == 0);
      o.front = o.empty ? '0 : held_words[0];
      o.back  = o.empty ? '0 : held_words[$];
      return o;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void check_field(input string field,
                                       input logic signed [DATA_W-1:0] want,
                                       input logic signed [DATA_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // responses are stable for the whole strobe cycle, so sample them mid-cycle
   always @(negedge clock) begin
      deq_outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: response with no transaction outstanding", $time);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("popped_value", want.popped, rsp_popped_value);
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
            check_field("front_value", want.front, rsp_front_value);
            check_field("back_value", want.back, rsp_back_value);
            check_field("entry_count", DATA_W'(want.count), DATA_W'(rsp_entry_count));
            check_field("is_empty", DATA_W'(want.empty), DATA_W'(rsp_is_empty));
            checked_count++;
         end
      end
   end

   task automatic send_item(input logic [KIND_W-1:0] kind,
                            input logic signed [DATA_W-1:0] value);
      logic            was_busy;
      deq_outcome_type o;
      start     <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      o = apply_deque_op(kind, value);
      pending_outcomes.push_back(o);
      sent_count++;
      if (o.status == deq_pkg::STATUS_PUSH_FULL) full_drops++;
      if (o.status == deq_pkg::STATUS_POP_EMPTY) empty_pops++;
      if (o.count > peak_count) peak_count = o.count;
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic test_empty_queue();
      gap_odds = 3;
      send_item(deq_pkg::KIND_QUERY, '0);
      send_item(deq_pkg::KIND_POP_FRONT, '0);
      send_item(deq_pkg::KIND_POP_BACK, random_word());
      for (int k = int'(deq_pkg::KIND_QUERY) + 1; k < 2 ** KIND_W; k++)
         send_item(KIND_W'(k), random_word());
   endtask

   task automatic test_single_entries();
      gap_odds = 2;
      send_item(deq_pkg::KIND_PUSH_FRONT, {1'b0, {(DATA_W-1){1'b1}}});
      send_item(deq_pkg::KIND_POP_BACK, '0);
      send_item(deq_pkg::KIND_PUSH_BACK, {1'b1, {(DATA_W-1){1'b0}}});
      send_item(deq_pkg::KIND_POP_FRONT, '1);
      send_item(deq_pkg::KIND_PUSH_FRONT, '1);
      send_item(deq_pkg::KIND_PUSH_BACK, '0);
      send_item(deq_pkg::KIND_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
      send_item(deq_pkg::KIND_QUERY, '1);
      send_item(deq_pkg::KIND_POP_FRONT, '0);
      send_item(deq_pkg::KIND_POP_BACK, '0);
      send_item(deq_pkg::KIND_POP_BACK, '0);
      send_item(deq_pkg::KIND_POP_FRONT, '0);
   endtask

   task automatic test_full_queue();
      gap_odds = 8;
      while (held_words.size() < DEPTH)
         send_item($urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT,
                   random_word());
      send_item(deq_pkg::KIND_PUSH_FRONT, random_word());
      send_item(deq_pkg::KIND_PUSH_BACK, random_word());
      send_item(deq_pkg::KIND_QUERY, random_word());
      send_item({KIND_W{1'b1}}, random_word());
      while (held_words.size() != 0)
         send_item($urandom_range(0, 1) ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT,
                   random_word());
      send_item(deq_pkg::KIND_POP_FRONT, random_word());
      send_item(deq_pkg::KIND_POP_BACK, random_word());
   endtask

   task automatic run_random_ops(input int unsigned total, input logic allow_gaps);
      int unsigned       done;
      int unsigned       run_len;
      int unsigned       push_pct;
      int unsigned       roll;
      logic [KIND_W-1:0] kind;
      done = 0;
      while (done < total) begin
         run_len = $urandom_range(10, 60);
         case ($urandom_range(0, 2))
            0:       push_pct = 70;
            1:       push_pct = 36;
            default: push_pct = 53;
         endcase
         gap_odds = allow_gaps ? $urandom_range(0, 4) : 0;
         for (int i = 0; i < run_len && done < total; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
               kind = KIND_W'(int'(deq_pkg::KIND_QUERY) + int'($urandom_range(0, 3)));
            else if (roll < push_pct)
               kind = $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT;
            else kind = $urandom_range(0, 1) ? deq_pkg::KIND_POP_BACK : deq_pkg::KIND_POP_FRONT;
            send_item(kind, random_word());
            done++;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_ops(600, 1'b1);
   endtask

   task automatic test_back_to_back();
      run_random_ops(150, 1'b0);
   endtask

   task automatic finish_run();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d transactions, %0d responses checked, peak occupancy %0d",
               sent_count, checked_count, peak_count);
      $display("pushes dropped on full queue: %0d, pops on empty queue: %0d",
               full_drops, empty_pops);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_single_entries();
      test_full_queue();
      test_random_traffic();
      test_back_to_back();
      finish_run();
   end

endmodule
